>>> rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the camera frame parser: header bytes, frame
// type codes, frame kinds, register indexes and the queued frame record.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int MAX_PAYLOAD = 20;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int DEC_BYTES   = 8;
  localparam int DEC_AW      = $clog2(DEC_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HDR_BYTE0 = 8'hAA;
  localparam logic [7:0] HDR_BYTE1 = 8'h30;
  localparam logic [7:0] HDR_BYTE2 = 8'h05;

  localparam logic [7:0] TYPE_CIRCLE = 8'hE1;
  localparam logic [7:0] TYPE_LINE   = 8'hE2;
  localparam logic [7:0] TYPE_STICK  = 8'hE3;
  localparam logic [7:0] TYPE_POWER  = 8'hE4;
  localparam logic [7:0] TYPE_BLOB   = 8'hE5;

  localparam logic [1:0] REG_MIN_RADIUS    = 2'd0;
  localparam logic [1:0] REG_MIN_MAGNITUDE = 2'd1;
  localparam logic [1:0] REG_BLOB_WRAP     = 2'd2;

  localparam logic [15:0] RST_MIN_RADIUS    = 16'd20;
  localparam logic [15:0] RST_MIN_MAGNITUDE = 16'd1700;
  localparam logic [7:0]  RST_BLOB_WRAP     = 8'd100;

  typedef enum logic [2:0] {
    KIND_CIRCLE = 3'd0,
    KIND_LINE   = 3'd1,
    KIND_POWER  = 3'd2,
    KIND_STICK  = 3'd3,
    KIND_BLOB   = 3'd4,
    KIND_OTHER  = 3'd5
  } frame_kind_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR1,
    PH_HDR2,
    PH_TYPE,
    PH_LEN,
    PH_PAYLOAD,
    PH_SUM
  } phase_t;

  typedef struct packed {
    frame_kind_t                   kind;
    logic [DEC_BYTES-1:0][7:0]     bytes;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [15:0] min_radius;
    logic [15:0] min_magnitude;
    logic [7:0]  blob_wrap_limit;
  } cfg_regs_t;

  function automatic frame_kind_t classify(input logic [7:0] code);
    frame_kind_t k;
    case (code)
      TYPE_CIRCLE: k = KIND_CIRCLE;
      TYPE_LINE:   k = KIND_LINE;
      TYPE_STICK:  k = KIND_STICK;
      TYPE_POWER:  k = KIND_POWER;
      TYPE_BLOB:   k = KIND_BLOB;
      default:     k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/camera_frame_parser_core.sv
// A good frame's record is queued, then decoded into the output register.
// Throughput: one received byte per cycle; the parser decides each byte in one
// step and the record queue (two frames deep) lets the decoder stall alone.
// Input stall rises only while the record queue is full.
// Reset (synchronous, active high) returns the parser to header hunt, empties
// the queue, clears the held centre and loads the register reset values.
// ----------------------------------------------------------------------------
// camera_frame_parser_core
// Camera link frame parser: header hunt, checksum check and frame decode.
// ----------------------------------------------------------------------------
module camera_frame_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        frame_kind,
  output logic [15:0]       word0,
  output logic [15:0]       word1,
  output logic [15:0]       word2,
  output logic [15:0]       word3,
  output logic [7:0]        line_flags,
  output logic signed [8:0] blob_x,
  output logic signed [8:0] blob_y,
  output logic signed [8:0] blob_size,
  output logic              circle_accepted,
  output logic [15:0]       held_x,
  output logic [15:0]       held_y
);

  cfp_pkg::cfg_regs_t  cfg;
  cfp_pkg::q_status_t  q_status;
  cfp_pkg::frame_rec_t push_rec, pop_rec;
  logic accept, push, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_radius      <= cfp_pkg::RST_MIN_RADIUS;
      cfg.min_magnitude   <= cfp_pkg::RST_MIN_MAGNITUDE;
      cfg.blob_wrap_limit <= cfp_pkg::RST_BLOB_WRAP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfp_pkg::REG_MIN_RADIUS:    cfg.min_radius      <= cfg_data;
        cfp_pkg::REG_MIN_MAGNITUDE: cfg.min_magnitude   <= cfg_data;
        cfp_pkg::REG_BLOB_WRAP:     cfg.blob_wrap_limit <= cfg_data[7:0];
        default:                    cfg.blob_wrap_limit <= cfg.blob_wrap_limit;
      endcase
    end
  end

  cfp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .push    (push),
    .rec     (push_rec)
  );

  cfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .status   (q_status)
  );

  cfp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_status        (q_status),
    .rec             (pop_rec),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_kind      (frame_kind),
    .word0           (word0),
    .word1           (word1),
    .word2           (word2),
    .word3           (word3),
    .line_flags      (line_flags),
    .blob_x          (blob_x),
    .blob_y          (blob_y),
    .blob_size       (blob_size),
    .circle_accepted (circle_accepted),
    .held_x          (held_x),
    .held_y          (held_y)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("frame record pushed into a full queue");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_accept_circle_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && circle_accepted |-> frame_kind == cfp_pkg::KIND_CIRCLE)
    else $error("centre update flagged on a non-circle frame");

  a_held_follows_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && circle_accepted |-> held_x == word0 && held_y == word1)
    else $error("held centre does not match accepted circle");
`endif

endmodule

>>> rtl/cfp_front.sv
// ----------------------------------------------------------------------------
// cfp_front
// Byte parser: hunts for the header, classifies the frame type, gathers the
// leading payload bytes and checks the running sum. Pushes one frame record
// per good frame.
// ----------------------------------------------------------------------------
module cfp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output cfp_pkg::frame_rec_t rec
);

  cfp_pkg::phase_t phase, phase_next;
  logic [7:0]                     running_sum;
  logic [7:0]                     sum_next;
  cfp_pkg::frame_kind_t           kind;
  logic [cfp_pkg::LEN_W-1:0]      length;
  logic [cfp_pkg::LEN_W-1:0]      idx;
  logic [cfp_pkg::LEN_W:0]        idx_inc;
  logic [cfp_pkg::DEC_BYTES-1:0][7:0] store;
  logic                           sum_ok;

  assign idx_inc = {1'b0, idx} + (cfp_pkg::LEN_W + 1)'(1);
  assign sum_ok  = (running_sum == rx_byte);

  // next state
  always_comb begin
    phase_next = phase;
    case (phase)
      cfp_pkg::PH_HUNT: begin
        if (rx_byte == cfp_pkg::HDR_BYTE0) phase_next = cfp_pkg::PH_HDR1;
      end
      cfp_pkg::PH_HDR1: begin
        phase_next = (rx_byte == cfp_pkg::HDR_BYTE1) ? cfp_pkg::PH_HDR2 : cfp_pkg::PH_HUNT;
      end
      cfp_pkg::PH_HDR2: begin
        phase_next = (rx_byte == cfp_pkg::HDR_BYTE2) ? cfp_pkg::PH_TYPE : cfp_pkg::PH_HUNT;
      end
      cfp_pkg::PH_TYPE: phase_next = cfp_pkg::PH_LEN;
      cfp_pkg::PH_LEN: begin
        if (rx_byte > 8'(cfp_pkg::MAX_PAYLOAD)) phase_next = cfp_pkg::PH_HUNT;
        else if (rx_byte == 8'd0)                phase_next = cfp_pkg::PH_SUM;
        else                                     phase_next = cfp_pkg::PH_PAYLOAD;
      end
      cfp_pkg::PH_PAYLOAD: begin
        if (idx_inc >= {1'b0, length}) phase_next = cfp_pkg::PH_SUM;
      end
      cfp_pkg::PH_SUM: phase_next = cfp_pkg::PH_HUNT;
      default:         phase_next = cfp_pkg::PH_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    sum_next = running_sum + rx_byte;
    push     = 1'b0;
    case (phase)
      cfp_pkg::PH_HUNT: sum_next = rx_byte;
      cfp_pkg::PH_SUM:  push     = accept && sum_ok;
      default:          push     = 1'b0;
    endcase
  end

  // bytes at or beyond the received length read as zero
  always_comb begin
    rec.kind = kind;
    for (int i = 0; i < cfp_pkg::DEC_BYTES; i++) begin
      rec.bytes[i] = (cfp_pkg::LEN_W'(i) < length) ? store[i] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cfp_pkg::PH_HUNT;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      running_sum <= sum_next;
      if (phase == cfp_pkg::PH_TYPE) kind <= cfp_pkg::classify(rx_byte);
      if (phase == cfp_pkg::PH_LEN) begin
        length <= rx_byte[cfp_pkg::LEN_W-1:0];
        idx    <= '0;
      end
      if (phase == cfp_pkg::PH_PAYLOAD) begin
        idx <= idx_inc[cfp_pkg::LEN_W-1:0];
        if (idx < cfp_pkg::LEN_W'(cfp_pkg::DEC_BYTES)) store[idx[cfp_pkg::DEC_AW-1:0]] <= rx_byte;
      end
    end
  end

endmodule

>>> rtl/cfp_queue.sv
// ----------------------------------------------------------------------------
// cfp_queue
// Short frame record queue between the parser and the decoder.
// ----------------------------------------------------------------------------
module cfp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cfp_pkg::frame_rec_t push_rec,
  input  logic                pop,
  output cfp_pkg::frame_rec_t pop_rec,
  output cfp_pkg::q_status_t  status
);

  cfp_pkg::frame_rec_t entries [cfp_pkg::QUEUE_DEPTH];
  logic [cfp_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [cfp_pkg::QUEUE_CW-1:0] count;
  logic do_push, do_pop;

  assign status.full  = (count == cfp_pkg::QUEUE_CW'(cfp_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign pop_rec = entries[rd_ptr];

  function automatic logic [cfp_pkg::QUEUE_AW-1:0] bump(input logic [cfp_pkg::QUEUE_AW-1:0] p);
    return (p == cfp_pkg::QUEUE_AW'(cfp_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_rec;
  end

endmodule

>>> rtl/cfp_back.sv
// ----------------------------------------------------------------------------
// cfp_back
// Frame decoder: takes a queued record, builds the result fields, updates the
// held circle centre and holds the result in the output register.
// ----------------------------------------------------------------------------
module cfp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  cfp_pkg::cfg_regs_t          cfg,
  input  cfp_pkg::q_status_t          q_status,
  input  cfp_pkg::frame_rec_t         rec,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  frame_kind,
  output logic [15:0]                 word0,
  output logic [15:0]                 word1,
  output logic [15:0]                 word2,
  output logic [15:0]                 word3,
  output logic [7:0]                  line_flags,
  output logic signed [8:0]           blob_x,
  output logic signed [8:0]           blob_y,
  output logic signed [8:0]           blob_size,
  output logic                        circle_accepted,
  output logic [15:0]                 held_x,
  output logic [15:0]                 held_y
);

  logic [15:0] held_centre_x, held_centre_y;
  logic [15:0] w0, w1, w2, w3;
  logic [15:0] w0_next, w1_next, w2_next, w3_next;
  logic [7:0]  flags_next;
  logic [8:0]  bx_next, by_next, bs_next;
  logic        acc_next;
  logic        is_circle_ok;

  function automatic logic [8:0] wrap(input logic [7:0] b, input logic [7:0] limit);
    return {(b > limit), b};
  endfunction

  assign pop = !q_status.empty && (!out_valid || !out_stall);

  assign w0 = {rec.bytes[0], rec.bytes[1]};
  assign w1 = {rec.bytes[2], rec.bytes[3]};
  assign w2 = {rec.bytes[4], rec.bytes[5]};
  assign w3 = {rec.bytes[6], rec.bytes[7]};

  assign is_circle_ok = (w0 != 16'd0) && (w1 != 16'd0) &&
                        (w2 >= cfg.min_radius) && (w3 >= cfg.min_magnitude);

  always_comb begin
    w0_next    = '0;
    w1_next    = '0;
    w2_next    = '0;
    w3_next    = '0;
    flags_next = '0;
    bx_next    = '0;
    by_next    = '0;
    bs_next    = '0;
    acc_next   = 1'b0;
    case (rec.kind)
      cfp_pkg::KIND_CIRCLE: begin
        w0_next  = w0;
        w1_next  = w1;
        w2_next  = w2;
        w3_next  = w3;
        acc_next = is_circle_ok;
      end
      cfp_pkg::KIND_LINE: begin
        w0_next    = w0;
        w1_next    = w1;
        flags_next = rec.bytes[4];
      end
      cfp_pkg::KIND_POWER: begin
        w0_next = w0;
        w1_next = w1;
        w2_next = w2;
      end
      cfp_pkg::KIND_BLOB: begin
        bx_next = wrap(rec.bytes[0], cfg.blob_wrap_limit);
        by_next = wrap(rec.bytes[1], cfg.blob_wrap_limit);
        bs_next = wrap(rec.bytes[2], cfg.blob_wrap_limit);
      end
      default: acc_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      held_centre_x <= '0;
      held_centre_y <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (acc_next) begin
          held_centre_x <= w0;
          held_centre_y <= w1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_kind      <= rec.kind;
      word0           <= w0_next;
      word1           <= w1_next;
      word2           <= w2_next;
      word3           <= w3_next;
      line_flags      <= flags_next;
      blob_x          <= bx_next;
      blob_y          <= by_next;
      blob_size       <= bs_next;
      circle_accepted <= acc_next;
      held_x          <= acc_next ? w0 : held_centre_x;
      held_y          <= acc_next ? w1 : held_centre_y;
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream regression of the camera frame parser: well-formed frames of
// every kind with random content, broken headers, bad checksums, oversize
// lengths and line noise, checked against a cycle-free parser model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef logic [7:0] payload_t [cfp_pkg::MAX_PAYLOAD];

  typedef struct packed {
    cfp_pkg::frame_kind_t kind;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic [7:0]  flags;
    logic [8:0]  bx;
    logic [8:0]  by;
    logic [8:0]  bsize;
    logic        accepted;
    logic [15:0] hx;
    logic [15:0] hy;
  } frame_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = 8'h00;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = cfp_pkg::REG_MIN_RADIUS;
  logic [15:0]       cfg_data = 16'h0000;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        frame_kind;
  logic [15:0]       word0, word1, word2, word3;
  logic [7:0]        line_flags;
  logic signed [8:0] blob_x, blob_y, blob_size;
  logic              circle_accepted;
  logic [15:0]       held_x, held_y;

  camera_frame_parser_core dut (.*);

  // Parser model state and register copies
  cfp_pkg::phase_t parse_phase = cfp_pkg::PH_HUNT;
  logic [7:0]  frame_sum = 8'h00;
  logic [7:0]  type_code = 8'h00;
  logic [7:0]  pay_len = 8'h00;
  logic [5:0]  pay_idx = 6'd0;
  logic [7:0]  pay_mem [cfp_pkg::MAX_PAYLOAD] = '{default: 8'h00};
  logic [15:0] centre_x = 16'h0000;
  logic [15:0] centre_y = 16'h0000;
  logic [15:0] thr_radius = cfp_pkg::RST_MIN_RADIUS;
  logic [15:0] thr_magnitude = cfp_pkg::RST_MIN_MAGNITUDE;
  logic [7:0]  wrap_limit = cfp_pkg::RST_BLOB_WRAP;

  logic [7:0]    link_bytes[$];
  frame_result_t pending_frames[$];
  int unsigned   bytes_pushed = 0;
  int unsigned   cfg_writes = 0;
  int unsigned   errors = 0;
  int unsigned   quiet_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            holds_asked = 0;
  int            holds_served = 0;
  int            hold_left = 0;
  logic          in_fire = 1'b0;

  initial forever #10 clk = ~clk;

  // ---------------- model ----------------
  function automatic logic [7:0] stored_byte(input int unsigned i);
    if (i >= cfp_pkg::MAX_PAYLOAD || i >= pay_len) return 8'h00;
    return pay_mem[i];
  endfunction

  function automatic logic [15:0] stored_word(input int unsigned i);
    return {stored_byte(i), stored_byte(i + 1)};
  endfunction

  function automatic logic [8:0] wrap_blob(input logic [7:0] b);
    return (b > wrap_limit) ? {1'b1, b} : {1'b0, b};
  endfunction

  function automatic frame_result_t decode_frame();
    frame_result_t r;
    r = '0;
    case (type_code)
      cfp_pkg::TYPE_CIRCLE: begin
        r.kind = cfp_pkg::KIND_CIRCLE;
        r.w0 = stored_word(0);
        r.w1 = stored_word(2);
        r.w2 = stored_word(4);
        r.w3 = stored_word(6);
        if (r.w0 != 0 && r.w1 != 0 && r.w2 >= thr_radius && r.w3 >= thr_magnitude) begin
          centre_x = r.w0;
          centre_y = r.w1;
          r.accepted = 1'b1;
        end
      end
      cfp_pkg::TYPE_LINE: begin
        r.kind = cfp_pkg::KIND_LINE;
        r.w0 = stored_word(0);
        r.w1 = stored_word(2);
        r.flags = stored_byte(4);
      end
      cfp_pkg::TYPE_POWER: begin
        r.kind = cfp_pkg::KIND_POWER;
        r.w0 = stored_word(0);
        r.w1 = stored_word(2);
        r.w2 = stored_word(4);
      end
      cfp_pkg::TYPE_STICK: r.kind = cfp_pkg::KIND_STICK;
      cfp_pkg::TYPE_BLOB: begin
        r.kind = cfp_pkg::KIND_BLOB;
        r.bx = wrap_blob(stored_byte(0));
        r.by = wrap_blob(stored_byte(1));
        r.bsize = wrap_blob(stored_byte(2));
      end
      default: r.kind = cfp_pkg::KIND_OTHER;
    endcase
    r.hx = centre_x;
    r.hy = centre_y;
    return r;
  endfunction

  // Advance the parser by one byte; returns 1 when a frame passes its checksum
  function automatic bit advance_parser(input logic [7:0] b, output frame_result_t r);
    bit done;
    done = 1'b0;
    r = '0;
    case (parse_phase)
      cfp_pkg::PH_HUNT: begin
        if (b == cfp_pkg::HDR_BYTE0) begin
          frame_sum = b;
          parse_phase = cfp_pkg::PH_HDR1;
        end
      end
      cfp_pkg::PH_HDR1: begin
        if (b == cfp_pkg::HDR_BYTE1) begin
          frame_sum = frame_sum + b;
          parse_phase = cfp_pkg::PH_HDR2;
        end else parse_phase = cfp_pkg::PH_HUNT;
      end
      cfp_pkg::PH_HDR2: begin
        if (b == cfp_pkg::HDR_BYTE2) begin
          frame_sum = frame_sum + b;
          parse_phase = cfp_pkg::PH_TYPE;
        end else parse_phase = cfp_pkg::PH_HUNT;
      end
      cfp_pkg::PH_TYPE: begin
        type_code = b;
        frame_sum = frame_sum + b;
        parse_phase = cfp_pkg::PH_LEN;
      end
      cfp_pkg::PH_LEN: begin
        pay_len = b;
        pay_idx = 6'd0;
        frame_sum = frame_sum + b;
        if (b > cfp_pkg::MAX_PAYLOAD) parse_phase = cfp_pkg::PH_HUNT;
        else if (b == 8'h00) parse_phase = cfp_pkg::PH_SUM;
        else parse_phase = cfp_pkg::PH_PAYLOAD;
      end
      cfp_pkg::PH_PAYLOAD: begin
        if (pay_idx < cfp_pkg::MAX_PAYLOAD) pay_mem[pay_idx] = b;
        pay_idx = pay_idx + 6'd1;
        frame_sum = frame_sum + b;
        if ({2'b00, pay_idx} >= pay_len) parse_phase = cfp_pkg::PH_SUM;
      end
      cfp_pkg::PH_SUM: begin
        if (frame_sum == b) begin
          r = decode_frame();
          done = 1'b1;
        end
        parse_phase = cfp_pkg::PH_HUNT;
      end
      default: parse_phase = cfp_pkg::PH_HUNT;
    endcase
    return done;
  endfunction

  function automatic string show(input frame_result_t r);
    return $sformatf("kind=%0d w=%h/%h/%h/%h flags=%h blob=%h/%h/%h acc=%b held=%h/%h",
                     r.kind, r.w0, r.w1, r.w2, r.w3, r.flags, r.bx, r.by, r.bsize,
                     r.accepted, r.hx, r.hy);
  endfunction

  // ---------------- monitor and scoreboard ----------------
  always @(posedge clk) begin
    frame_result_t predicted, got, want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cfp_pkg::REG_MIN_RADIUS:    thr_radius = cfg_data;
          cfp_pkg::REG_MIN_MAGNITUDE: thr_magnitude = cfg_data;
          cfp_pkg::REG_BLOB_WRAP:     wrap_limit = cfg_data[7:0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        if (advance_parser(rx_byte, predicted)) pending_frames.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        got = '{kind: cfp_pkg::frame_kind_t'(frame_kind), w0: word0, w1: word1, w2: word2,
                w3: word3, flags: line_flags, bx: blob_x, by: blob_y, bsize: blob_size,
                accepted: circle_accepted, hx: held_x, hy: held_y};
        if (pending_frames.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected frame: %s", show(got));
        end else begin
          want = pending_frames.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("frame mismatch\n  expected %s\n  actual   %s", show(want), show(got));
          end
        end
      end
    end
  end

  // ---------------- byte driver ----------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        rx_byte <= link_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- result stall, with long hold-offs on request ----------------
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_served < holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("camera_frame_parser_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    bytes_pushed++;
  endtask

  task automatic push_frame(input logic [7:0] code, input int unsigned len,
                            input payload_t pl, input bit bad_sum);
    logic [7:0] sum;
    sum = cfp_pkg::HDR_BYTE0 + cfp_pkg::HDR_BYTE1 + cfp_pkg::HDR_BYTE2 + code + len[7:0];
    push_byte(cfp_pkg::HDR_BYTE0);
    push_byte(cfp_pkg::HDR_BYTE1);
    push_byte(cfp_pkg::HDR_BYTE2);
    push_byte(code);
    push_byte(len[7:0]);
    for (int i = 0; i < len && i < cfp_pkg::MAX_PAYLOAD; i++) begin
      push_byte(pl[i]);
      sum = sum + pl[i];
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    push_byte(sum);
  endtask

  function automatic payload_t pack_words(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c, input logic [15:0] d);
    payload_t p;
    p = '{default: 8'h00};
    {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]} = {a, b, c, d};
    return p;
  endfunction

  function automatic payload_t rand_payload();
    payload_t p;
    int r;
    for (int i = 0; i < cfp_pkg::MAX_PAYLOAD; i++) begin
      r = $urandom_range(99);
      p[i] = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(255));
    end
    return p;
  endfunction

  function automatic logic [15:0] rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 16'h0000;
    if (r < 24) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [15:0] near_threshold(input logic [15:0] t);
    case ($urandom_range(4))
      0: return t;
      1: return t - 16'd1;
      2: return t + 16'd1;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] near_limit(input logic [7:0] t);
    case ($urandom_range(4))
      0: return t;
      1: return t + 8'd1;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_random_frame(input bit bad_sum);
    payload_t    pl;
    logic [7:0]  code;
    int unsigned natural_len, len;
    int          r;
    pl = rand_payload();
    case ($urandom_range(5))
      0: begin
        code = cfp_pkg::TYPE_CIRCLE;
        natural_len = 8;
        {pl[0], pl[1]} = rand_word();
        {pl[2], pl[3]} = rand_word();
        {pl[4], pl[5]} = near_threshold(thr_radius);
        {pl[6], pl[7]} = near_threshold(thr_magnitude);
      end
      1: begin
        code = cfp_pkg::TYPE_LINE;
        natural_len = 5;
      end
      2: begin
        code = cfp_pkg::TYPE_POWER;
        natural_len = 6;
      end
      3: begin
        code = cfp_pkg::TYPE_STICK;
        natural_len = 0;
      end
      4: begin
        code = cfp_pkg::TYPE_BLOB;
        natural_len = 3;
        pl[0] = near_limit(wrap_limit);
        pl[1] = near_limit(wrap_limit);
        pl[2] = near_limit(wrap_limit);
      end
      default: begin
        code = 8'($urandom_range(255));
        natural_len = $urandom_range(8);
      end
    endcase
    r = $urandom_range(99);
    len = (r < 70) ? natural_len : (r < 90) ? $urandom_range(8) :
          $urandom_range(cfp_pkg::MAX_PAYLOAD);
    push_frame(code, len, pl, bad_sum);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned stop;
    int          r;
    stop = bytes_pushed + n;
    while (bytes_pushed < stop) begin
      r = $urandom_range(99);
      if (r < 75) begin
        push_random_frame(1'b0);
      end else if (r < 85) begin
        push_random_frame(1'b1);
      end else if (r < 90) begin
        push_frame(8'($urandom_range(255)), $urandom_range(cfp_pkg::MAX_PAYLOAD + 1, 255),
                   rand_payload(), 1'b0);
      end else if (r < 95) begin
        // broken header, with the odd accidental match left to the model
        push_byte(cfp_pkg::HDR_BYTE0);
        if ($urandom_range(1)) push_byte(cfp_pkg::HDR_BYTE1);
        push_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_idle();
    while (link_bytes.size() != 0 || in_valid || pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    int unsigned target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (cfg_writes != target) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] radius, input logic [15:0] magnitude,
                            input logic [7:0] limit);
    write_reg(cfp_pkg::REG_MIN_RADIUS, radius);
    write_reg(cfp_pkg::REG_MIN_MAGNITUDE, magnitude);
    write_reg(cfp_pkg::REG_BLOB_WRAP, {8'h00, limit});
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase one: sparse sender gaps, heavy result stalls, reset thresholds
    send_idle_pct = 9;
    recv_idle_pct = 70;
    push_byte(8'h00);
    push_byte(8'hFF);
    // circle exactly at both thresholds updates the centre
    push_frame(cfp_pkg::TYPE_CIRCLE, 8, pack_words(16'h1234, 16'h5678,
               cfp_pkg::RST_MIN_RADIUS, cfp_pkg::RST_MIN_MAGNITUDE), 1'b0);
    push_frame(cfp_pkg::TYPE_CIRCLE, 8, pack_words(16'h0000, 16'h0101, 16'hFFFF, 16'hFFFF),
               1'b0);
    push_frame(cfp_pkg::TYPE_CIRCLE, 8, pack_words(16'h0202, 16'h0000, 16'hFFFF, 16'hFFFF),
               1'b0);
    push_frame(cfp_pkg::TYPE_CIRCLE, 8, pack_words(16'hFFFF, 16'hFFFF,
               cfp_pkg::RST_MIN_RADIUS - 16'd1, 16'hFFFF), 1'b0);
    push_frame(cfp_pkg::TYPE_CIRCLE, 8, pack_words(16'h0001, 16'h0001, 16'hFFFF,
               cfp_pkg::RST_MIN_MAGNITUDE - 16'd1), 1'b0);
    push_frame(cfp_pkg::TYPE_CIRCLE, 8, pack_words(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
               1'b0);
    push_frame(cfp_pkg::TYPE_LINE, 5, pack_words(16'hABCD, 16'h00FF, 16'hFF00, 16'h0000),
               1'b0);
    push_frame(cfp_pkg::TYPE_POWER, 6, pack_words(16'h8001, 16'h7FFE, 16'hFFFF, 16'h1111),
               1'b0);
    push_frame(cfp_pkg::TYPE_STICK, 0, rand_payload(), 1'b0);
    // blob bytes at, just above and far above the wrap limit
    push_frame(cfp_pkg::TYPE_BLOB, 3, pack_words(16'h6465, 16'hFF00, 16'h0000, 16'h0000),
               1'b0);
    push_frame(8'h00, 3, rand_payload(), 1'b0);
    push_frame(8'hFF, cfp_pkg::MAX_PAYLOAD, rand_payload(), 1'b0);
    // short payload: the missing bytes decode as zero
    push_frame(cfp_pkg::TYPE_CIRCLE, 3, pack_words(16'h1234, 16'h5678, 16'hFFFF, 16'hFFFF),
               1'b0);
    push_frame(cfp_pkg::TYPE_LINE, cfp_pkg::MAX_PAYLOAD, rand_payload(), 1'b0);
    push_frame(cfp_pkg::TYPE_CIRCLE, 8, pack_words(16'h0505, 16'h0606, 16'hFFFF, 16'hFFFF),
               1'b1);
    push_frame(cfp_pkg::TYPE_BLOB, cfp_pkg::MAX_PAYLOAD + 1, rand_payload(), 1'b0);
    push_frame(cfp_pkg::TYPE_BLOB, 255, rand_payload(), 1'b0);
    // header mismatches: the failing byte is not taken as a new header start
    push_byte(cfp_pkg::HDR_BYTE0);
    push_frame(cfp_pkg::TYPE_STICK, 0, rand_payload(), 1'b0);
    push_byte(cfp_pkg::HDR_BYTE0);
    push_byte(cfp_pkg::HDR_BYTE1);
    push_frame(cfp_pkg::TYPE_STICK, 0, rand_payload(), 1'b0);
    push_frame(cfp_pkg::TYPE_STICK, 0, rand_payload(), 1'b0);
    random_traffic(60);
    wait_idle();
    set_config(16'h0000, 16'h0000, 8'h00);

    // Phase two: heavy sender gaps, sparse result stalls
    send_idle_pct = 70;
    recv_idle_pct = 9;
    random_traffic(60);
    wait_idle();
    set_config(16'hFFFF, 16'hFFFF, 8'hFF);

    // Phase three: no idling either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(40);
    wait_idle();
    set_config(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               8'($urandom_range(255)));
    // hold the result side off while short frames keep arriving
    holds_asked++;
    repeat (20) push_frame(cfp_pkg::TYPE_STICK, 0, rand_payload(), 1'b0);
    random_traffic(40);
    wait_idle();

    repeat (10) @(posedge clk);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("camera_frame_parser_core regression: pass");
    end else begin
      $display("camera_frame_parser_core regression: fail");
    end
    $finish;
  end

endmodule
